FILE: design/ds402_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds402_pkg
// Shared types, register codes, SDO constants and the drive state decode
// for the DS402 SDO status monitor.
// ----------------------------------------------------------------------------
package ds402_pkg;

   // input transaction: frame or millisecond tick
   typedef struct packed {
      logic        req_type;
      logic [10:0] frame_id;
      logic [63:0] frame_payload;
   } ds402_req_type;

   // result transaction
   typedef struct packed {
      logic               frame_matched;
      logic               poll_request;
      logic [2:0]         drive_state;
      logic [15:0]        status_bits;
      logic signed [31:0] position_now;
      logic signed [31:0] velocity_now;
      logic signed [7:0]  mode_shown;
      logic               link_up;
      logic               target_hit;
      logic               homing_done;
   } ds402_rsp_type;

   // configuration registers
   typedef struct packed {
      logic [6:0]  node_id;
      logic [15:0] poll_period_ms;
      logic [15:0] link_timeout_ms;
   } ds402_cfg_type;

   // stored drive objects and link flag
   typedef struct packed {
      logic [15:0]        status_val;
      logic [2:0]         drive_state;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [7:0]  mode;
      logic               link;
   } ds402_obj_type;

   // register indexes
   localparam logic [1:0] CSR_NODE_ID      = 2'd0;
   localparam logic [1:0] CSR_POLL_PERIOD  = 2'd1;
   localparam logic [1:0] CSR_LINK_TIMEOUT = 2'd2;

   localparam logic [6:0]  NODE_ID_RST      = 7'd1;
   localparam logic [15:0] POLL_PERIOD_RST  = 16'd50;
   localparam logic [15:0] LINK_TIMEOUT_RST = 16'd1000;

   // request type codes
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // sdo framing
   localparam logic [10:0] SDO_RESP_BASE = 11'h580;
   localparam logic [7:0]  SDO_CS_MASK   = 8'hE0;
   localparam logic [7:0]  SDO_CS_UPLOAD = 8'h40;
   localparam logic [7:0]  SDO_CS_DNLD   = 8'h60;

   // object dictionary indexes
   localparam logic [15:0] OBJ_DRIVE_STATUS = 16'h6041;
   localparam logic [15:0] OBJ_MODE_SHOWN   = 16'h6061;
   localparam logic [15:0] OBJ_POSITION     = 16'h6064;
   localparam logic [15:0] OBJ_VELOCITY     = 16'h606C;

   // drive state codes
   localparam logic [2:0] DS_NOT_READY  = 3'd0;
   localparam logic [2:0] DS_DISABLED   = 3'd1;
   localparam logic [2:0] DS_READY      = 3'd2;
   localparam logic [2:0] DS_SWITCHED   = 3'd3;
   localparam logic [2:0] DS_ENABLED    = 3'd4;
   localparam logic [2:0] DS_QUICK_STOP = 3'd5;
   localparam logic [2:0] DS_FAULT      = 3'd7;

   function automatic logic [2:0] decode_state(input logic [15:0] sw);
      logic rdy, son, ena, flt, qs, sod;
      logic [2:0] st;
      rdy = sw[0];
      son = sw[1];
      ena = sw[2];
      flt = sw[3];
      qs  = sw[5];
      sod = sw[6];
      if (!rdy && !son && !ena && !flt && !sod)
         st = DS_NOT_READY;
      else if (!rdy && !son && !ena && sod && !flt)
         st = DS_DISABLED;
      else if (rdy && !son && !ena && !sod && qs && !flt)
         st = DS_READY;
      else if (rdy && son && !ena && !sod && qs && !flt)
         st = DS_SWITCHED;
      else if (rdy && son && ena && !sod && qs && !flt)
         st = DS_ENABLED;
      else if (rdy && son && ena && !sod && !qs && !flt)
         st = DS_QUICK_STOP;
      else if (flt)
         st = DS_FAULT;
      else
         st = DS_NOT_READY;
      return st;
   endfunction

endpackage

FILE: design/ds402_sdo_status_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds402_sdo_status_monitor
// Watches SDO responses from one DS402 drive and millisecond ticks, keeps
// status word, drive state, position, velocity, mode and link state, and
// asks for a status word poll when the poll period runs out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | content
//  req_    | in        | req_valid / req_ready  | frame or tick (ds402_req_type)
//  rsp_    | out       | rsp_valid / rsp_ready  | one result per transaction
//  csr_    | in        | csr_valid / csr_ready  | register index and write data
//
//  one transaction per cycle while rsp_ready stays high; an accepted
//  transaction passes the input register, then the result register
//  the state update is one pass of shallow logic between the two registers
//  reset is synchronous, returns registers to their defaults and clears state
//  a stalled rsp_ready fills the result and input registers, then req_ready
//  drops; the register port is always ready
// ----------------------------------------------------------------------------
module ds402_sdo_status_monitor #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // input transactions
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ds402_pkg::ds402_req_type req_data,
   // results
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ds402_pkg::ds402_rsp_type rsp_data,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);
   import ds402_pkg::*;

   // configuration
   ds402_cfg_type cfg_ff;

   // input stage
   logic          s1_valid_ff;
   ds402_req_type s1_req_ff;

   // result stage
   logic          rsp_valid_ff;
   ds402_rsp_type rsp_data_ff;

   // monitor state
   ds402_obj_type          obj_ff;
   ds402_obj_type          obj_in;
   logic [TIMER_WIDTH-1:0] poll_ff;
   logic [TIMER_WIDTH-1:0] poll_in;
   logic [TIMER_WIDTH-1:0] silence_ff;
   logic [TIMER_WIDTH-1:0] silence_in;
   ds402_rsp_type          rsp_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   // result register empties or is taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // the input stage item is processed and its state update commits
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ds402_step #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_step (
      .cfg        (cfg_ff),
      .req        (s1_req_ff),
      .obj_ff     (obj_ff),
      .poll_ff    (poll_ff),
      .silence_ff (silence_ff),
      .obj_in     (obj_in),
      .poll_in    (poll_in),
      .silence_in (silence_in),
      .rsp        (rsp_in)
   );

   // control state, registers and monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.node_id         <= NODE_ID_RST;
         cfg_ff.poll_period_ms  <= POLL_PERIOD_RST;
         cfg_ff.link_timeout_ms <= LINK_TIMEOUT_RST;
         obj_ff                 <= '0;
         poll_ff                <= '0;
         silence_ff             <= '0;
      end else begin
         // register writes; an index past the list is dropped
         if (csr_valid) begin
            unique case (csr_index)
               CSR_NODE_ID:      cfg_ff.node_id         <= csr_wdata[6:0];
               CSR_POLL_PERIOD:  cfg_ff.poll_period_ms  <= csr_wdata;
               CSR_LINK_TIMEOUT: cfg_ff.link_timeout_ms <= csr_wdata;
               default: ;
            endcase
         end

         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // state commits once per processed transaction
         if (s1_move) begin
            obj_ff     <= obj_in;
            poll_ff    <= poll_in;
            silence_ff <= silence_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

FILE: design/ds402_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds402_step
// Next-state and result logic for one transaction: timers, frame match,
// sdo upload decode and object update.
// ----------------------------------------------------------------------------
module ds402_step #(
   parameter int TIMER_WIDTH = 16
) (
   input  ds402_pkg::ds402_cfg_type  cfg,
   input  ds402_pkg::ds402_req_type  req,
   input  ds402_pkg::ds402_obj_type  obj_ff,
   input  logic [TIMER_WIDTH-1:0]    poll_ff,
   input  logic [TIMER_WIDTH-1:0]    silence_ff,
   output ds402_pkg::ds402_obj_type  obj_in,
   output logic [TIMER_WIDTH-1:0]    poll_in,
   output logic [TIMER_WIDTH-1:0]    silence_in,
   output ds402_pkg::ds402_rsp_type  rsp
);
   import ds402_pkg::*;

   localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   logic [TIMER_WIDTH-1:0] poll_inc;
   logic [TIMER_WIDTH-1:0] silence_inc;
   logic                   poll_fire;
   logic                   silence_fire;
   logic                   matched;
   logic [7:0]             cs;
   logic [15:0]            idx;
   logic [31:0]            value;
   logic                   is_upload;

   // saturating timers
   assign poll_inc    = (poll_ff == '1) ? poll_ff : poll_ff + 1'b1;
   assign silence_inc = (silence_ff == '1) ? silence_ff : silence_ff + 1'b1;
   assign poll_fire    = CMP_W'(poll_inc) > CMP_W'(cfg.poll_period_ms);
   assign silence_fire = CMP_W'(silence_inc) > CMP_W'(cfg.link_timeout_ms);

   assign cs        = req.frame_payload[7:0];
   assign idx       = req.frame_payload[23:8];
   assign value     = req.frame_payload[63:32];
   assign matched   = (req.req_type == REQ_FRAME) &&
                      (req.frame_id == SDO_RESP_BASE + {4'd0, cfg.node_id});
   assign is_upload = (cs != SDO_CS_DNLD) && ((cs & SDO_CS_MASK) == SDO_CS_UPLOAD);

   always_comb begin
      obj_in     = obj_ff;
      poll_in    = poll_ff;
      silence_in = silence_ff;
      if (req.req_type == REQ_TICK) begin
         poll_in    = poll_fire ? '0 : poll_inc;
         silence_in = silence_inc;
         if (silence_fire) begin
            obj_in.link = 1'b0;
         end
      end else if (matched) begin
         obj_in.link = 1'b1;
         silence_in  = '0;
         if (is_upload) begin
            case (idx)
               OBJ_DRIVE_STATUS: begin
                  obj_in.status_val  = value[15:0];
                  obj_in.drive_state = decode_state(value[15:0]);
               end
               OBJ_POSITION: obj_in.position = value;
               OBJ_VELOCITY: obj_in.velocity = value;
               OBJ_MODE_SHOWN: obj_in.mode = value[7:0];
               default: ;
            endcase
         end
      end
   end

   // results show the state after the update
   always_comb begin
      rsp.frame_matched  = matched;
      rsp.poll_request   = (req.req_type == REQ_TICK) && poll_fire;
      rsp.drive_state    = obj_in.drive_state;
      rsp.status_bits    = obj_in.status_val;
      rsp.position_now   = obj_in.position;
      rsp.velocity_now   = obj_in.velocity;
      rsp.mode_shown     = obj_in.mode;
      rsp.link_up        = obj_in.link;
      rsp.target_hit     = obj_in.status_val[10];
      rsp.homing_done    = obj_in.status_val[12];
   end

endmodule

FILE: design/ds402_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ds402_checker
// Port-level checks for the DS402 SDO status monitor, bound to the top.
// ----------------------------------------------------------------------------
module ds402_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input ds402_pkg::ds402_rsp_type rsp_data
);
   import ds402_pkg::*;

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // a tick never reports a matched frame, a frame never polls
   a_poll_vs_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.poll_request && rsp_data.frame_matched))
      else $error("poll request on a matched frame");

   // a matched frame always brings the link up
   a_match_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_matched |-> rsp_data.link_up)
      else $error("matched frame without link up");

   // flags follow the stored status word
   a_status_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.target_hit == rsp_data.status_bits[10] &&
                    rsp_data.homing_done == rsp_data.status_bits[12])
      else $error("status flags disagree with status word");

   // drive state agrees with the decode of the stored status word
   a_state_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive_state == decode_state(rsp_data.status_bits))
      else $error("drive state does not match status word");

endmodule

bind ds402_sdo_status_monitor ds402_checker u_ds402_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DS402 SDO status monitor. A directed set of
// SDO frames and ticks covers field extremes, every stored object, every
// drive state and the ignored command specifiers. Random traffic then runs
// under several register settings, including zero thresholds and a tick
// run across both thresholds. A built-in status predictor computes each
// result, and the monitor compares every field in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ds402_pkg::*;

   // run limits
   localparam int          CYCLE_LIMIT  = 1500000;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          SETTLE_TICKS = 6;
   // write to the unused register slot, must be ignored
   localparam logic [1:0]  CSR_SPARE    = 2'd3;
   // sdo request base, used only to build near-miss identifiers
   localparam logic [10:0] SDO_REQ_BASE = 11'h600;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   ds402_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   ds402_rsp_type rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   ds402_sdo_status_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // frames and ticks still to be sent, and the status reports they must produce
   ds402_req_type frames_and_ticks[$];
   ds402_rsp_type reports_due[$];

   int error_count = 0;
   int cycle_count = 0;

   // ---------------------------------------------------------------------------
   // status predictor: own copy of registers and drive state
   // ---------------------------------------------------------------------------
   logic [6:0]         cfg_node    = NODE_ID_RST;
   logic [15:0]        cfg_poll    = POLL_PERIOD_RST;
   logic [15:0]        cfg_timeout = LINK_TIMEOUT_RST;

   logic [15:0]        poll_ms   = '0;
   logic [15:0]        quiet_ms  = '0;
   logic               link_seen = 1'b0;
   logic [15:0]        last_status = '0;
   logic [2:0]         last_state  = DS_NOT_READY;
   logic signed [31:0] last_pos  = '0;
   logic signed [31:0] last_vel  = '0;
   logic signed [7:0]  last_mode = '0;

   function automatic ds402_rsp_type predict_status_report(input ds402_req_type it);
      ds402_rsp_type rep;
      logic [7:0]    cs;
      logic [15:0]   obj;
      logic [31:0]   val;
      logic [15:0]   sw;
      cs  = it.frame_payload[7:0];
      obj = it.frame_payload[23:8];
      val = it.frame_payload[63:32];
      rep = '0;
      if (it.req_type == REQ_TICK) begin
         // both timers saturate at all ones
         if (poll_ms != 16'hFFFF) poll_ms = poll_ms + 16'd1;
         if (quiet_ms != 16'hFFFF) quiet_ms = quiet_ms + 16'd1;
         if (poll_ms > cfg_poll) begin
            rep.poll_request = 1'b1;
            poll_ms = '0;
         end
         if (quiet_ms > cfg_timeout) link_seen = 1'b0;
      end else if (it.frame_id == SDO_RESP_BASE + {4'b0, cfg_node}) begin
         rep.frame_matched = 1'b1;
         // upload responses only; download replies and aborts just refresh the link
         if (cs != SDO_CS_DNLD && (cs & SDO_CS_MASK) == SDO_CS_UPLOAD) begin
            case (obj)
               OBJ_DRIVE_STATUS: begin
                  sw = val[15:0];
                  last_status = sw;
                  // {fault, switch-on disabled, enabled, switched on, ready, quick stop}
                  casez ({sw[3], sw[6], sw[2], sw[1], sw[0], sw[5]})
                     6'b1?????: last_state = DS_FAULT;
                     6'b01000?: last_state = DS_DISABLED;
                     6'b00000?: last_state = DS_NOT_READY;
                     6'b000011: last_state = DS_READY;
                     6'b000111: last_state = DS_SWITCHED;
                     6'b001111: last_state = DS_ENABLED;
                     6'b001110: last_state = DS_QUICK_STOP;
                     default:   last_state = DS_NOT_READY;
                  endcase
               end
               OBJ_POSITION:   last_pos  = val;
               OBJ_VELOCITY:   last_vel  = val;
               OBJ_MODE_SHOWN: last_mode = val[7:0];
               default: ;
            endcase
         end
         link_seen = 1'b1;
         quiet_ms  = '0;
      end
      rep.drive_state    = last_state;
      rep.status_bits    = last_status;
      rep.position_now   = last_pos;
      rep.velocity_now   = last_vel;
      rep.mode_shown     = last_mode;
      rep.link_up        = link_seen;
      rep.target_hit     = last_status[10];
      rep.homing_done    = last_status[12];
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // item builders
   // ---------------------------------------------------------------------------
   function automatic ds402_req_type tick_item();
      ds402_req_type it;
      it.req_type      = REQ_TICK;
      // identifier and payload are ignored on ticks, keep them busy anyway
      it.frame_id      = 11'($urandom);
      it.frame_payload = {$urandom, $urandom};
      return it;
   endfunction

   function automatic ds402_req_type sdo_frame(input logic [10:0] id, input logic [7:0] cs,
                                               input logic [15:0] obj, input logic [31:0] val);
      ds402_req_type it;
      it.req_type      = REQ_FRAME;
      it.frame_id      = id;
      // subindex is never checked, so it is random
      it.frame_payload = {val, 8'($urandom), obj, cs};
      return it;
   endfunction

   // any expedited or segmented upload specifier
   function automatic logic [7:0] upload_cs();
      return SDO_CS_UPLOAD | (8'($urandom) & ~SDO_CS_MASK);
   endfunction

   // status word with its low bits often set to a canonical state pattern
   function automatic logic [15:0] random_status();
      logic [15:0] sw;
      sw = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 6))
            0: sw[6:0] = 7'h00;
            1: sw[6:0] = 7'h40;
            2: sw[6:0] = 7'h21;
            3: sw[6:0] = 7'h23;
            4: sw[6:0] = 7'h27;
            5: sw[6:0] = 7'h07;
            default: sw[6:0] = 7'h08;
         endcase
      end
      return sw;
   endfunction

   function automatic ds402_req_type random_item();
      logic [10:0] own_id;
      logic [10:0] other_id;
      int          pick;
      own_id = SDO_RESP_BASE + {4'b0, cfg_node};
      pick   = $urandom_range(0, 99);
      if (pick < 45) begin
         return tick_item();
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: return sdo_frame(own_id, upload_cs(), OBJ_DRIVE_STATUS,
                                {16'($urandom), random_status()});
            1: return sdo_frame(own_id, upload_cs(), OBJ_POSITION, $urandom);
            2: return sdo_frame(own_id, upload_cs(), OBJ_VELOCITY, $urandom);
            default: return sdo_frame(own_id, upload_cs(), OBJ_MODE_SHOWN, $urandom);
         endcase
      end else if (pick < 90) begin
         // download reply or arbitrary specifier on a known object
         return sdo_frame(own_id, ($urandom_range(0, 1) != 0) ? SDO_CS_DNLD : 8'($urandom),
                          OBJ_DRIVE_STATUS, $urandom);
      end else if (pick < 94) begin
         // upload of an object this block does not keep
         return sdo_frame(own_id, upload_cs(),
                          ($urandom_range(0, 1) != 0) ? OBJ_DRIVE_STATUS + 16'd1
                                                      : 16'($urandom), $urandom);
      end else begin
         case ($urandom_range(0, 2))
            0: other_id = SDO_REQ_BASE + {4'b0, cfg_node};
            1: other_id = own_id ^ 11'd1;
            default: other_id = 11'($urandom);
         endcase
         if (other_id == own_id) other_id = own_id ^ 11'h400;
         return sdo_frame(other_id, upload_cs(), OBJ_POSITION, $urandom);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // driver: bursts of transactions with random gaps
   // ---------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;
   bit fast_send  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reports_due.push_back(predict_status_report(req_data));
         end
         // payload only moves once the held transaction is taken
         if (!req_valid || req_ready) begin
            if (gap_left != 0 && !fast_send) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (frames_and_ticks.size() != 0) begin
               req_data  <= frames_and_ticks.pop_front();
               req_valid <= 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  // some bursts run straight into the next one
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: stall pattern changes when the 6-bit phase wraps, plus requested holdoffs
   // ---------------------------------------------------------------------------
   int       hold_asks   = 0;
   int       hold_served = 0;
   int       hold_left   = 0;
   int       stall_mode  = 0;
   bit [5:0] stall_phase = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_phase = stall_phase + 6'd1;
         if (stall_phase == 6'd0) stall_mode = $urandom_range(0, 3);
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_served != hold_asks) begin
            // long holdoff so the block fills and backs up the sender
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) != 0);
               2: rsp_ready <= (stall_phase[1:0] == 2'd0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every accepted result against the oldest prediction
   // ---------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count = error_count + 1;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      ds402_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reports_due.size() == 0) begin
            error_count = error_count + 1;
            $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_data);
         end else begin
            want = reports_due.pop_front();
            check_field("frame_matched",  want.frame_matched,  rsp_data.frame_matched);
            check_field("poll_request",   want.poll_request,   rsp_data.poll_request);
            check_field("drive_state",    want.drive_state,    rsp_data.drive_state);
            check_field("status_bits",    want.status_bits,    rsp_data.status_bits);
            check_field("position_now",   want.position_now,   rsp_data.position_now);
            check_field("velocity_now",   want.velocity_now,   rsp_data.velocity_now);
            check_field("mode_shown",     want.mode_shown,     rsp_data.mode_shown);
            check_field("link_up",        want.link_up,        rsp_data.link_up);
            check_field("target_hit",     want.target_hit,     rsp_data.target_hit);
            check_field("homing_done",    want.homing_done,    rsp_data.homing_done);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------------------

   // wait until everything sent has come back, then let the pipe run empty;
   // checked at the falling edge so driver updates of the same edge are seen
   task automatic settle();
      while (frames_and_ticks.size() != 0 || req_valid || reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NODE_ID:      cfg_node    = val[6:0];
         CSR_POLL_PERIOD:  cfg_poll    = val;
         CSR_LINK_TIMEOUT: cfg_timeout = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] node, input logic [15:0] period,
                            input logic [15:0] timeout);
      write_reg(CSR_NODE_ID, node);
      write_reg(CSR_POLL_PERIOD, period);
      write_reg(CSR_LINK_TIMEOUT, timeout);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) frames_and_ticks.push_back(random_item());
   endtask

   initial begin
      logic [10:0] own_id;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed set at reset defaults, node 1
      own_id = SDO_RESP_BASE + {4'b0, NODE_ID_RST};
      frames_and_ticks.push_back(tick_item());
      frames_and_ticks.push_back(sdo_frame(11'h000, upload_cs(), OBJ_POSITION, 32'h1234_5678));
      frames_and_ticks.push_back(sdo_frame(11'h7FF, upload_cs(), OBJ_POSITION, 32'h1234_5678));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h43, OBJ_POSITION, 32'h7FFF_FFFF));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_POSITION, 32'h8000_0000));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4F, OBJ_VELOCITY, 32'h8000_0000));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h42, OBJ_VELOCITY, 32'h7FFF_FFFF));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4F, OBJ_MODE_SHOWN, 32'hFFFF_FF80));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4F, OBJ_MODE_SHOWN, 32'h0000_007F));
      // one status word per drive state from disabled to fault, then the no-rule, all-ones and zero words
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0040));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0021));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0023));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_1427));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0007));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0048));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'hFFFF_0001));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_FFFF));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h4B, OBJ_DRIVE_STATUS, 32'h0000_0000));
      // download reply, abort and unknown object refresh the link only
      frames_and_ticks.push_back(sdo_frame(own_id, SDO_CS_DNLD, OBJ_POSITION, 32'h0BAD_0BAD));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h80, OBJ_VELOCITY, 32'h0BAD_0BAD));
      frames_and_ticks.push_back(sdo_frame(own_id, 8'h43, 16'h6040, 32'h0BAD_0BAD));
      frames_and_ticks.push_back(ds402_req_type'{REQ_FRAME, own_id, 64'hFFFF_FFFF_FFFF_FFFF});
      frames_and_ticks.push_back(ds402_req_type'{REQ_FRAME, own_id ^ 11'h7FF, 64'h0});
      frames_and_ticks.push_back(tick_item());
      settle();

      // zero thresholds: poll and link drop on every tick; high node bits masked
      configure(16'hFF7F, 16'd0, 16'd0);
      queue_random(150);
      hold_asks = hold_asks + 1;
      settle();

      // smallest in-range thresholds, plus a write to the unused slot
      configure(16'($urandom_range(1, 127)), 16'd1, 16'd1);
      write_reg(CSR_SPARE, 16'($urandom));
      queue_random(75);
      // sender pauses until every result is back
      settle();
      queue_random(75);
      settle();

      // node zero with short timers
      configure(16'h0000, 16'd3, 16'd7);
      queue_random(150);
      settle();

      configure(16'($urandom), 16'($urandom_range(2, 30)), 16'($urandom_range(5, 60)));
      queue_random(200);
      hold_asks = hold_asks + 1;
      settle();

      // unbroken tick run past both the link timeout and the poll period
      configure(16'h0042, 16'd20, 16'd19);
      fast_send = 1'b1;
      frames_and_ticks.push_back(sdo_frame(SDO_RESP_BASE + 11'h042, upload_cs(),
                                           OBJ_DRIVE_STATUS, {16'($urandom), random_status()}));
      for (int i = 0; i < 30; i++) frames_and_ticks.push_back(tick_item());
      settle();
      fast_send = 1'b0;

      // back to the reset values
      configure({9'b0, NODE_ID_RST}, POLL_PERIOD_RST, LINK_TIMEOUT_RST);
      queue_random(150);
      settle();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
